[src/bpa_pkg.sv]
// Shared types and constants for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_ORD = 2'd1;
	localparam logic [1:0] ST_NO_FREE = 2'd2;
	localparam logic       ACT_ALLOC  = 1'b0;
	localparam logic       ACT_FREE   = 1'b1;
endpackage

[src/buddy_page_allocator_unit.sv]
// Top level of the buddy page allocator: sequencer, free-list memory and counters.
`timescale 1ns / 1ps
//
// Channel | Ports                                  | Handshake
// request | action, block_order, start_page        | start & !busy
// result  | status, granted_page, granted_order    | done strobe, one cycle
//
// One request at a time; busy stays high until the done cycle has passed.
// A bad order reports in the cycle after acceptance. An allocate that
// hits its own order passes through scan, pop, read wait and done; each
// split adds a split step and a rescan from the requested order. A free
// compares each entry in a find and a check step and, on a hit, moves each
// later entry down in a read and a write step, then appends and reports done.
// Reset clears the heads and every length but the top order's, which it sets
// to one, and marks the top-order slot as holding page zero until it is first
// written; no other entry is read before it is written, so the memory needs
// no clearing pass. The receiver cannot stall: done is high for exactly one
// cycle per transaction.
module buddy_page_allocator_unit #(
	parameter int TOP_ORDER = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       action,
	input  logic [3:0] block_order,
	input  logic [9:0] start_page,
	output logic       done,
	output logic [1:0] status,
	output logic [9:0] granted_page,
	output logic [3:0] granted_order
);
	import bpa_pkg::*;

	localparam int DEPTH = (2 << TOP_ORDER) - 1;
	localparam int AW    = TOP_ORDER + 1;
	localparam int LW    = TOP_ORDER + 1;
	localparam int NO    = TOP_ORDER + 1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SCAN  = 11'b00000000010,
		S_POP   = 11'b00000000100,
		S_POPW  = 11'b00000001000,
		S_SPL2  = 11'b00000010000,
		S_FIND  = 11'b00000100000,
		S_FCHK  = 11'b00001000000,
		S_SHRD  = 11'b00010000000,
		S_SHWR  = 11'b00100000000,
		S_APP   = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [LW-1:0] len_q  [NO];
	logic [LW-1:0] head_q [NO];
	logic [9:0]    mem    [DEPTH];
	logic [9:0]    rd_q;
	logic [3:0]    ord_q, k_q;
	logic [9:0]    b_q;
	logic [LW-1:0] pos_q;
	logic          act_q;
	logic [1:0]    st_q;
	logic [9:0]    pg_q;
	logic          top_fresh_q;

	// Slot address of position pos in list k.
	function automatic logic [AW-1:0] slot(input logic [3:0] k, input logic [LW-1:0] head,
		input logic [LW-1:0] pos);
		logic [AW:0] base;
		logic [LW-1:0] msk;
		base = (AW+1)'((2 << TOP_ORDER) - (2 << (TOP_ORDER - k)));
		msk  = LW'((1 << (TOP_ORDER - k)) - 1);
		return AW'(base + (AW+1)'((head + pos) & msk));
	endfunction

	function automatic logic [LW-1:0] cap(input logic [3:0] k);
		return LW'(1 << (TOP_ORDER - k));
	endfunction

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [9:0]    wdata;
	logic          re;
	logic [9:0]    bud;
	logic [3:0]    km1;
	assign bud = b_q ^ (10'd1 << k_q);
	assign km1 = k_q - 4'd1;

	always_comb begin
		we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
		unique case (state_q)
			S_POP: begin
				re = 1'b1; raddr = slot(k_q, head_q[k_q], '0);
			end
			S_FIND: begin
				re = 1'b1; raddr = slot(k_q, head_q[k_q], pos_q);
			end
			S_SHRD: begin
				re = 1'b1; raddr = slot(k_q, head_q[k_q], pos_q + LW'(1));
			end
			S_SHWR: begin
				we = 1'b1; waddr = slot(k_q, head_q[k_q], pos_q); wdata = rd_q;
			end
			S_POPW: begin
				we = (k_q != ord_q) && (len_q[km1] < cap(km1));
				waddr = slot(km1, head_q[km1], len_q[km1]); wdata = rd_q;
			end
			S_SPL2: begin
				we = len_q[k_q] < cap(k_q);
				waddr = slot(k_q, head_q[k_q], len_q[k_q]); wdata = b_q;
			end
			S_APP: begin
				we = len_q[k_q] < cap(k_q);
				waddr = slot(k_q, head_q[k_q], len_q[k_q]); wdata = b_q;
			end
			default: ;
		endcase
	end

	// The top-order slot reads as page zero until it is first written.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= (top_fresh_q && raddr == AW'(DEPTH - 1)) ? '0 : mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NO; i++) begin
				len_q[i]  <= (i == TOP_ORDER) ? LW'(1) : '0;
				head_q[i] <= '0;
			end
			st_q <= ST_OK; pg_q <= '0; ord_q <= '0; k_q <= '0; b_q <= '0;
			pos_q <= '0; act_q <= 1'b0; top_fresh_q <= 1'b1;
		end else begin
			if (we && waddr == AW'(DEPTH - 1)) top_fresh_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					ord_q <= block_order; k_q <= block_order; act_q <= action;
					b_q <= start_page & 10'((1 << TOP_ORDER) - 1); pos_q <= '0;
					pg_q <= '0;
					st_q <= (32'(block_order) > TOP_ORDER) ? ST_BAD_ORD : ST_OK;
					if (32'(block_order) > TOP_ORDER) state_q <= S_DONE;
					else if (action == ACT_ALLOC) state_q <= S_SCAN;
					else if (32'(block_order) == TOP_ORDER) state_q <= S_APP;
					else state_q <= S_FIND;
				end
				// Walk upward one order per cycle.
				S_SCAN: begin
					if (len_q[k_q] != '0) state_q <= S_POP;
					else if (32'(k_q) == TOP_ORDER) begin
						st_q <= ST_NO_FREE; state_q <= S_DONE;
					end else k_q <= k_q + 4'd1;
				end
				S_POP: begin
					head_q[k_q] <= (head_q[k_q] + LW'(1)) & (cap(k_q) - LW'(1));
					len_q[k_q]  <= len_q[k_q] - LW'(1);
					state_q <= S_POPW;
				end
				S_POPW: begin
					if (k_q == ord_q) begin
						pg_q <= rd_q; state_q <= S_DONE;
					end else begin
						if (len_q[km1] < cap(km1)) len_q[km1] <= len_q[km1] + LW'(1);
						b_q <= rd_q + (10'd1 << km1);
						k_q <= km1;
						state_q <= S_SPL2;
					end
				end
				S_SPL2: begin
					if (len_q[k_q] < cap(k_q)) len_q[k_q] <= len_q[k_q] + LW'(1);
					k_q <= ord_q; state_q <= S_SCAN;
				end
				S_FIND: begin
					if (pos_q >= len_q[k_q]) state_q <= S_APP;
					else state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (rd_q == bud) begin
						if (bud < b_q) b_q <= bud;
						state_q <= S_SHRD;
					end else begin
						pos_q <= pos_q + LW'(1); state_q <= S_FIND;
					end
				end
				// Shift later entries down over the removed one.
				S_SHRD: begin
					if (pos_q + LW'(1) >= len_q[k_q]) begin
						len_q[k_q] <= len_q[k_q] - LW'(1);
						pos_q <= '0;
						k_q <= k_q + 4'd1;
						state_q <= (32'(k_q) + 1 >= TOP_ORDER) ? S_APP : S_FIND;
					end else state_q <= S_SHWR;
				end
				S_SHWR: begin
					pos_q <= pos_q + LW'(1); state_q <= S_SHRD;
				end
				S_APP: begin
					if (len_q[k_q] < cap(k_q)) len_q[k_q] <= len_q[k_q] + LW'(1);
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign done          = state_q == S_DONE;
	assign status        = st_q;
	assign granted_page  = (st_q == ST_OK && act_q == ACT_ALLOC) ? pg_q : '0;
	assign granted_order = (st_q == ST_OK && act_q == ACT_ALLOC) ? ord_q : '0;

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q[TOP_ORDER] <= LW'(1)) else $error("top list overflow");
endmodule

[tb/bpa_scoreboard.sv]
// Scoreboard for the buddy page allocator: free-list predictor and result checker.
`timescale 1ns / 1ps
module bpa_scoreboard #(
	parameter int TOP_ORDER = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       action,
	input  logic [3:0] block_order,
	input  logic [9:0] start_page,
	input  logic       done,
	input  logic [1:0] status,
	input  logic [9:0] granted_page,
	input  logic [3:0] granted_order,
	output int         fail_count,
	output int         pending
);
	import bpa_pkg::*;

	localparam int SLOTS = (2 << TOP_ORDER) - 1;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] page;
		logic [3:0] order;
	} grant_t;

	grant_t      grant_q[$];
	logic [9:0]  free_slots[0:SLOTS-1];
	int unsigned free_len[0:TOP_ORDER];
	int unsigned free_head[0:TOP_ORDER];

	function automatic int unsigned cap_of(int k);
		return 1 << (TOP_ORDER - k);
	endfunction

	function automatic int unsigned slot_of(int k, int unsigned pos);
		int unsigned base;
		base = (2 << TOP_ORDER) - (2 << (TOP_ORDER - k));
		return base + ((free_head[k] + pos) & (cap_of(k) - 1));
	endfunction

	// drop the block when the list is already at capacity
	task automatic push_free(int k, logic [9:0] page);
		if (free_len[k] < cap_of(k)) begin
			free_slots[slot_of(k, free_len[k])] = page;
			free_len[k]++;
		end
	endtask

	task automatic pop_free(int k, output logic [9:0] page);
		page = free_slots[slot_of(k, 0)];
		free_head[k] = (free_head[k] + 1) & (cap_of(k) - 1);
		free_len[k]--;
	endtask

	// compact the list over the removed position
	task automatic remove_free(int k, int unsigned pos);
		for (int unsigned i = pos; i + 1 < free_len[k]; i++)
			free_slots[slot_of(k, i)] = free_slots[slot_of(k, i + 1)];
		free_len[k]--;
	endtask

	task automatic predict_grant(logic act, logic [3:0] ord, logic [9:0] pg,
			output grant_t g);
		int          k;
		int unsigned pos;
		logic [9:0]  b;
		logic [9:0]  bud;
		g = '0;
		if (ord > TOP_ORDER) begin
			g.status = ST_BAD_ORD;
		end else if (act == ACT_ALLOC) begin
			forever begin
				k = ord;
				while (k <= TOP_ORDER && free_len[k] == 0)
					k++;
				if (k > TOP_ORDER) begin
					g.status = ST_NO_FREE;
					break;
				end
				pop_free(k, b);
				if (k == ord) begin
					g.status = ST_OK;
					g.page = b;
					g.order = ord;
					break;
				end
				push_free(k - 1, b);
				push_free(k - 1, b + 10'(1 << (k - 1)));
			end
		end else begin
			k = ord;
			b = pg & 10'((1 << TOP_ORDER) - 1);
			while (k < TOP_ORDER) begin
				bud = b ^ 10'(1 << k);
				pos = 0;
				while (pos < free_len[k] && free_slots[slot_of(k, pos)] != bud)
					pos++;
				if (pos >= free_len[k])
					break;
				remove_free(k, pos);
				if (bud < b)
					b = bud;
				k++;
			end
			push_free(k, b);
			g.status = ST_OK;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t exp_g;
		grant_t new_g;
		int     errs;
		if (!arst_n) begin
			grant_q.delete();
			for (int k = 0; k <= TOP_ORDER; k++) begin
				free_len[k] = 0;
				free_head[k] = 0;
			end
			free_slots[slot_of(TOP_ORDER, 0)] = '0;
			free_len[TOP_ORDER] = 1;
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (done) begin
				if (grant_q.size() == 0) begin
					$error("result with nothing outstanding");
					errs++;
				end else begin
					exp_g = grant_q[0];
					grant_q.delete(0);
					if (status !== exp_g.status) begin
						$error("status: expected %0d, got %0d", exp_g.status, status);
						errs++;
					end
					if (granted_page !== exp_g.page) begin
						$error("granted_page: expected %0d, got %0d", exp_g.page,
							granted_page);
						errs++;
					end
					if (granted_order !== exp_g.order) begin
						$error("granted_order: expected %0d, got %0d", exp_g.order,
							granted_order);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				predict_grant(action, block_order, start_page, new_g);
				grant_q.insert(grant_q.size(), new_g);
			end
			fail_count <= fail_count + errs;
			pending <= grant_q.size();
		end
	end
endmodule

[tb/buddy_page_allocator_unit_tb.sv]
// Testbench top for the buddy page allocator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module buddy_page_allocator_unit_tb;
	import bpa_pkg::*;

	localparam int TOP_ORDER = 10;
	localparam int RANDOM_ITEMS = 800;

	typedef struct packed {
		logic [9:0] page;
		logic [3:0] order;
	} block_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       action = ACT_ALLOC;
	logic [3:0] block_order = '0;
	logic [9:0] start_page = '0;
	logic       done;
	logic [1:0] status;
	logic [9:0] granted_page;
	logic [3:0] granted_order;
	int         fail_count;
	int         pending;

	// blocks the allocator handed out that the stimulus may give back
	block_t     held_q[$];
	// action of each transaction still waiting for its result
	logic       act_q[$];
	int         alloc_cnt = 0;
	int         free_cnt = 0;

	always #4 clk = ~clk;

	buddy_page_allocator_unit #(.TOP_ORDER(TOP_ORDER)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .block_order(block_order), .start_page(start_page),
		.done(done), .status(status), .granted_page(granted_page),
		.granted_order(granted_order)
	);

	bpa_scoreboard #(.TOP_ORDER(TOP_ORDER)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .block_order(block_order), .start_page(start_page),
		.done(done), .status(status), .granted_page(granted_page),
		.granted_order(granted_order), .fail_count(fail_count), .pending(pending)
	);

	// Track grants at the falling edge, where every signal is settled. A
	// transaction about to be taken is queued before its result can show up.
	always @(negedge clk) begin
		logic a;
		if (arst_n) begin
			if (done && act_q.size() != 0) begin
				a = act_q[0];
				act_q.delete(0);
				if (a == ACT_ALLOC && status == ST_OK)
					held_q.insert(held_q.size(), {granted_page, granted_order});
			end
			if (start && !busy)
				act_q.insert(act_q.size(), action);
		end
	end

	// Present one transaction and hold it until the block takes it.
	task automatic send(logic act, logic [3:0] ord, logic [9:0] pg);
		start <= 1'b1;
		action <= act;
		block_order <= ord;
		start_page <= pg;
		if (act == ACT_ALLOC)
			alloc_cnt++;
		else
			free_cnt++;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Pick the next random transaction: mostly allocations of small orders
	// and frees of blocks that were really granted, some noise frees.
	task automatic send_random();
		int     r;
		int     idx;
		block_t blk;
		r = $urandom_range(99);
		if (r < 48) begin
			if ($urandom_range(9) == 0)
				send(ACT_ALLOC, 4'($urandom_range(15)), 10'($urandom));
			else
				send(ACT_ALLOC, 4'($urandom_range(4)), 10'($urandom));
		end else if (r < 88 && held_q.size() != 0) begin
			idx = $urandom_range(held_q.size() - 1);
			blk = held_q[idx];
			held_q.delete(idx);
			send(ACT_FREE, blk.order, blk.page);
		end else begin
			send(ACT_FREE, 4'($urandom_range(15)), 10'($urandom));
		end
	endtask

	initial begin
		int burst;
		int sent;
		int guard;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		send(ACT_ALLOC, 4'd11, 10'd0);     // order too large
		send(ACT_ALLOC, 4'd15, 10'd1023);
		send(ACT_FREE, 4'd12, 10'd3);      // free with order too large
		send(ACT_FREE, 4'd10, 10'd0);      // top list full, block dropped
		send(ACT_ALLOC, 4'd10, 10'd0);     // whole space
		send(ACT_ALLOC, 4'd0, 10'd0);      // nothing left
		send(ACT_FREE, 4'd10, 10'd1023);   // unaligned free at the top order
		send(ACT_ALLOC, 4'd10, 10'd0);
		send(ACT_FREE, 4'd10, 10'd0);
		send(ACT_ALLOC, 4'd0, 10'd1023);   // split all the way down
		send(ACT_ALLOC, 4'd0, 10'd0);
		send(ACT_ALLOC, 4'd3, 10'd0);
		send(ACT_ALLOC, 4'd10, 10'd0);     // no block that large
		send(ACT_FREE, 4'd0, 10'd1);       // buddy still in use
		send(ACT_FREE, 4'd0, 10'd0);       // merges upward
		send(ACT_FREE, 4'd3, 10'd8);
		send(ACT_FREE, 4'd3, 10'd8);       // double free
		send(ACT_ALLOC, 4'd9, 10'd0);
		send(ACT_ALLOC, 4'd5, 10'd0);
		send(ACT_FREE, 4'd9, 10'd512);
		send(ACT_FREE, 4'd5, 10'd37);
		idle(3);

		// random part, bursts with random gaps; some long bursts run back to back
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_random();
				sent++;
			end
			idle($urandom_range(0, 1) ? $urandom_range(1, 12) : 0);
		end
		start <= 1'b0;

		// drain the outstanding results, then let the block settle
		guard = 0;
		while (pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		$display("Ran %0d allocations and %0d frees, including bad orders and noise frees.",
			alloc_cnt, free_cnt);
		if (fail_count == 0 && pending == 0)
			$display("buddy_page_allocator_unit test passed");
		else
			$display("buddy_page_allocator_unit test failed");
		$finish;
	end

	// hard stop for a hung handshake
	initial begin
		#200ms;
		$display("buddy_page_allocator_unit test failed");
		$finish;
	end
endmodule

[filelist.f]
src/bpa_pkg.sv
src/buddy_page_allocator_unit.sv
tb/bpa_scoreboard.sv
tb/buddy_page_allocator_unit_tb.sv
